@@ rtl/clmd_pkg.sv @@
// Shared types, character codes and status codes for the Content-Length deframer.
package clmd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last_byte;
  } out_item_t;

  localparam logic [2:0] ST_PAYLOAD    = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd2;
  localparam logic [2:0] ST_BAD_SEP    = 3'd3;
  localparam logic [2:0] ST_EARLY_END  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG   = 3'd5;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned PREFIX_LEN  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // "Content-Length: "
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = 8'h43; // C
      4'd1:  c = 8'h6F; // o
      4'd2:  c = 8'h6E; // n
      4'd3:  c = 8'h74; // t
      4'd4:  c = 8'h65; // e
      4'd5:  c = 8'h6E; // n
      4'd6:  c = 8'h74; // t
      4'd7:  c = 8'h2D; // -
      4'd8:  c = 8'h4C; // L
      4'd9:  c = 8'h65; // e
      4'd10: c = 8'h6E; // n
      4'd11: c = 8'h67; // g
      4'd12: c = 8'h74; // t
      4'd13: c = 8'h68; // h
      4'd14: c = 8'h3A; // :
      4'd15: c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/clmd_if.sv @@
// Valid/ready channel interfaces for the deframer input and result streams.
interface clmd_in_if;
  logic               valid;
  logic               ready;
  clmd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clmd_out_if;
  logic                valid;
  logic                ready;
  clmd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/content_length_message_deframer.sv @@
// Content-Length deframer: takes one stream byte per cycle while ready, emits payload bytes and status.
// Throughput: one input byte per clock, sustained, while results are taken each cycle.
// A result passes from the parser into the result queue and from the queue into the output
//   register before it is presented on the output channel.
// Input ready drops only when the two-entry result queue is full.
// Reset (asynchronous, active low) returns the parser to the header phase and empties
//   the queue and the output register; no clearing pass is needed.
module content_length_message_deframer #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clmd_in_if.sink    in_i,
  clmd_out_if.source out_o
);

  logic                in_fire;
  logic                res_valid;
  clmd_pkg::out_item_t res;
  logic                push;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  clmd_pkg::out_item_t q_data;

  assign in_i.ready = !q_full;
  assign in_fire    = in_i.valid && in_i.ready;
  assign push       = res_valid;

  clmd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .item_i      (in_i.data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  clmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  clmd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .data_i  (q_data),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.end_of_input) |->
      (push && (res.status == clmd_pkg::ST_EARLY_END)))
    else $error("end of input transfer without early end result");

  a_non_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.status != clmd_pkg::ST_PAYLOAD)) |->
      ((out_o.data.out_byte == 8'h00) && !out_o.data.last_byte))
    else $error("status result carries byte or last flag");

endmodule

@@ rtl/clmd_front.sv @@
// Header parser and framing state machine: one input byte per transfer, zero or one result.
module clmd_front #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  clmd_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output clmd_pkg::out_item_t res_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_SEP_CR  = 2'd1;
  localparam logic [1:0] PH_SEP_LF  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;
  localparam int unsigned PROD_W    = LENGTH_BITS + 4;

  logic [1:0]             phase_q, phase_d;
  logic                   seen_cr_q, seen_cr_d;
  logic [4:0]             hdr_pos_q, hdr_pos_d;
  logic                   mismatch_q, mismatch_d;
  logic                   num_ended_q, num_ended_d;
  logic                   num_started_q, num_started_d;
  logic                   overflow_q, overflow_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;

  logic [7:0]        b;
  logic              is_digit;
  logic              restart;
  logic [PROD_W-1:0] len_ext;
  logic [PROD_W-1:0] next_len;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= clmd_pkg::CHAR_ZERO) && (b <= clmd_pkg::CHAR_NINE);
  assign len_ext  = {4'b0000, length_q};
  // length * 10 + digit; the low nibble of an ASCII digit is its value
  assign next_len = (len_ext << 3) + (len_ext << 1) + {{(PROD_W-4){1'b0}}, b[3:0]};

  always_comb begin
    phase_d       = phase_q;
    seen_cr_d     = seen_cr_q;
    hdr_pos_d     = hdr_pos_q;
    mismatch_d    = mismatch_q;
    num_ended_d   = num_ended_q;
    num_started_d = num_started_q;
    overflow_d    = overflow_q;
    length_d      = length_q;
    remain_d      = remain_q;
    restart       = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (fire_i) begin
      if (item_i.end_of_input) begin
        restart      = 1'b1;
        res_valid_o  = 1'b1;
        res_o.status = clmd_pkg::ST_EARLY_END;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (seen_cr_q && (b == clmd_pkg::CHAR_LF)) begin
              if (mismatch_q || !hdr_pos_q[4]) begin
                restart      = 1'b1;
                res_valid_o  = 1'b1;
                res_o.status = clmd_pkg::ST_BAD_PREFIX;
              end else if (overflow_q) begin
                restart      = 1'b1;
                res_valid_o  = 1'b1;
                res_o.status = clmd_pkg::ST_TOO_LONG;
              end else begin
                phase_d = PH_SEP_CR;
              end
            end else begin
              if (b == clmd_pkg::CHAR_CR) begin
                seen_cr_d = 1'b1;
              end
              if (!hdr_pos_q[4]) begin
                if (b != clmd_pkg::prefix_char(hdr_pos_q[3:0])) begin
                  mismatch_d = 1'b1;
                end
                hdr_pos_d = hdr_pos_q + 5'd1;
              end else if (!num_ended_q) begin
                if (is_digit) begin
                  num_started_d = 1'b1;
                  if (!overflow_q) begin
                    if (next_len[PROD_W-1:LENGTH_BITS] != 4'b0000) begin
                      overflow_d = 1'b1;
                    end else begin
                      length_d = next_len[LENGTH_BITS-1:0];
                    end
                  end
                end else if (!((b == clmd_pkg::CHAR_SPACE) && !num_started_q)) begin
                  num_ended_d = 1'b1;
                end
              end
            end
          end
          PH_SEP_CR: begin
            if (b == clmd_pkg::CHAR_CR) begin
              phase_d = PH_SEP_LF;
            end else begin
              restart      = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = clmd_pkg::ST_BAD_SEP;
            end
          end
          PH_SEP_LF: begin
            if (b != clmd_pkg::CHAR_LF) begin
              restart      = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = clmd_pkg::ST_BAD_SEP;
            end else if (length_q == '0) begin
              restart      = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = clmd_pkg::ST_EMPTY;
            end else begin
              remain_d = length_q;
              phase_d  = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res_valid_o    = 1'b1;
            res_o.out_byte = b;
            res_o.status   = clmd_pkg::ST_PAYLOAD;
            if (remain_q <= LENGTH_BITS'(1)) begin
              restart         = 1'b1;
              res_o.last_byte = 1'b1;
            end else begin
              remain_d = remain_q - LENGTH_BITS'(1);
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
      end
    end

    if (restart) begin
      phase_d       = PH_HEADER;
      seen_cr_d     = 1'b0;
      hdr_pos_d     = '0;
      mismatch_d    = 1'b0;
      num_ended_d   = 1'b0;
      num_started_d = 1'b0;
      overflow_d    = 1'b0;
      length_d      = '0;
      remain_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEADER;
      seen_cr_q     <= 1'b0;
      hdr_pos_q     <= '0;
      mismatch_q    <= 1'b0;
      num_ended_q   <= 1'b0;
      num_started_q <= 1'b0;
      overflow_q    <= 1'b0;
      length_q      <= '0;
      remain_q      <= '0;
    end else begin
      phase_q       <= phase_d;
      seen_cr_q     <= seen_cr_d;
      hdr_pos_q     <= hdr_pos_d;
      mismatch_q    <= mismatch_d;
      num_ended_q   <= num_ended_d;
      num_started_q <= num_started_d;
      overflow_q    <= overflow_d;
      length_q      <= length_d;
      remain_q      <= remain_d;
    end
  end

  // Prefix position saturates at the prefix length
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= 5'(clmd_pkg::PREFIX_LEN))
    else $error("header position past prefix length");

  // Payload phase always carries a nonzero byte count
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (remain_q != '0))
    else $error("payload phase with zero bytes remaining");

endmodule

@@ rtl/clmd_fifo.sv @@
// Small result queue between the parser and the output stage.
module clmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clmd_pkg::out_item_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output clmd_pkg::out_item_t pop_data_o
);

  localparam int unsigned PTR_W = (clmd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(clmd_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(clmd_pkg::QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W+1)'(clmd_pkg::QUEUE_DEPTH);

  clmd_pkg::out_item_t entry_q [clmd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]      count_q, count_d;

  assign full_o     = (count_q == DEPTH_CNT);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + (PTR_W+1)'(1);
      2'b01:   count_d = count_q - (PTR_W+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full result queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty result queue");

endmodule

@@ rtl/clmd_back.sv @@
// Output register stage: drains the result queue onto the output channel.
module clmd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  clmd_pkg::out_item_t data_i,
  output logic                pop_o,
  clmd_out_if.source          out_o
);

  logic                out_valid_q, out_valid_d;
  clmd_pkg::out_item_t out_data_q;
  logic                load;

  assign load        = !out_valid_q || out_o.ready;
  assign pop_o       = load && !empty_i;
  assign out_valid_d = load ? !empty_i : out_valid_q;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule
